// ----- src/dhkp_pkg.sv -----
// shared types, constants and modular arithmetic helpers for the key pair block
// no dependencies
package dhkp_pkg;

  localparam int MOD_BITS   = 16;
  localparam int NUM_MUL    = 4;
  localparam int NUM_ROUNDS = 2 * MOD_BITS + 1;
  localparam int NUM_STAGES = NUM_ROUNDS * MOD_BITS;

  localparam logic [MOD_BITS-1:0] RESET_MODULUS   = MOD_BITS'(7489);
  localparam logic [MOD_BITS-1:0] RESET_GENERATOR = MOD_BITS'(2);
  localparam logic [MOD_BITS-1:0] MOD_ONE         = MOD_BITS'(1);
  localparam logic [MOD_BITS-1:0] MOD_TWO         = MOD_BITS'(2);

  localparam logic REG_MODULUS   = 1'b0;
  localparam logic REG_GENERATOR = 1'b1;

  typedef struct packed {
    logic [MOD_BITS-1:0] x;
    logic [MOD_BITS-1:0] y;
    logic [MOD_BITS-1:0] p;
  } mul_t;

  typedef mul_t [1:0] mul_pair_t;

  typedef struct packed {
    logic [MOD_BITS-1:0]  sec_a;
    logic [MOD_BITS-1:0]  sec_b;
    logic [MOD_BITS-1:0]  pub_a;
    logic [MOD_BITS-1:0]  pub_b;
    mul_t [NUM_MUL-1:0]   mul;
  } stage_t;

  typedef struct packed {
    logic en;
    logic valid;
  } cell_ctrl_t;

  // (x + y) mod m for x, y < m
  function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] x,
                                                  input logic [MOD_BITS-1:0] y,
                                                  input logic [MOD_BITS-1:0] m);
    logic [MOD_BITS-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  // one exponent bit: set up accumulator times base when bit set (else times one), and base squared
  function automatic mul_pair_t lane_setup(input logic [MOD_BITS-1:0] acc,
                                           input logic [MOD_BITS-1:0] base,
                                           input logic                bit_i);
    mul_pair_t r;
    r[0].x = acc;
    r[0].y = bit_i ? base : MOD_ONE;
    r[0].p = '0;
    r[1].x = base;
    r[1].y = base;
    r[1].p = '0;
    return r;
  endfunction

endpackage

// ----- src/dhkp_cell.sv -----
// one step of four interleaved modular multiplications, registered
// depends on dhkp_pkg
module dhkp_cell
  import dhkp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [MOD_BITS-1:0] modulus_i,
  input  stage_t              data_i,
  output logic                valid_o,
  output stage_t              data_o
);

  logic   valid_q;
  stage_t data_q, data_d;

  always_comb begin
    logic [MOD_BITS-1:0] dbl;
    data_d = data_i;
    for (int i = 0; i < NUM_MUL; i++) begin
      dbl = add_mod(data_i.mul[i].p, data_i.mul[i].p, modulus_i);
      data_d.mul[i].p = data_i.mul[i].y[MOD_BITS-1] ?
                        add_mod(dbl, data_i.mul[i].x, modulus_i) : dbl;
      data_d.mul[i].y = data_i.mul[i].y << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.en) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTH
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.en |=> $stable(valid_q))
    else $error("cell valid changed while stalled");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.en |=> (valid_q == $past(ctrl_i.valid)))
    else $error("cell valid did not follow its neighbour");
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.en && ctrl_i.valid) |=> (data_q.mul[0].y == ($past(data_i.mul[0].y) << 1)))
    else $error("multiplier bits not shifted");
`endif

endmodule

// ----- src/diffie_hellman_key_pair.sv -----
// top level of the key pair block: configuration registers, chain of cells
// and output register; depends on dhkp_pkg and dhkp_cell
//
// usage
//   input channel: secret_a_i/secret_b_i with in_valid_i; a request is taken
//   when in_valid_i is high and in_stall_o is low
//   output channel: public_a_o, public_b_o, key_a_o, key_b_o with out_valid_o;
//   a result is taken when out_valid_o is high and out_stall_i is low
//   config: cfg_we_i writes cfg_data_i to modulus (index 0) or generator (1)
//   chain: one cell per multiplier bit, one round of cells per exponent bit plus
//   one reduction round, then the output register
//   throughput: one request per cycle unless stalled, every cell stage works on its own request
//   stall: while a result waits and out_stall_i is high the whole chain holds,
//   otherwise requests keep flowing
//   reset: chain and output emptied, modulus 7489, generator 2
module diffie_hellman_key_pair
  import dhkp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [MOD_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MOD_BITS-1:0] secret_a_i,
  input  logic [MOD_BITS-1:0] secret_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MOD_BITS-1:0] public_a_o,
  output logic [MOD_BITS-1:0] public_b_o,
  output logic [MOD_BITS-1:0] key_a_o,
  output logic [MOD_BITS-1:0] key_b_o
);

  logic [MOD_BITS-1:0] modulus_q, generator_q;
  logic                en;
  logic                out_valid_q;
  logic [MOD_BITS-1:0] pub_a_q, pub_b_q, key_a_q, key_b_q;

  logic   cell_valid [NUM_STAGES];
  stage_t cell_data  [NUM_STAGES];
  logic   entry_valid [NUM_ROUNDS];
  stage_t entry_data  [NUM_ROUNDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= RESET_MODULUS;
      generator_q <= RESET_GENERATOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODULUS:   modulus_q   <= cfg_data_i;
        REG_GENERATOR: generator_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
    if (k == 0) begin : g_reduce
      always_comb begin
        entry_valid[k]       = in_valid_i;
        entry_data[k]        = '0;
        entry_data[k].sec_a  = secret_a_i;
        entry_data[k].sec_b  = secret_b_i;
        entry_data[k].mul[0] = '{x: MOD_ONE, y: generator_q, p: '0};
      end
    end else begin : g_exp
      localparam int J = (k <= MOD_BITS) ? (k - 1) : (k - 1 - MOD_BITS);
      stage_t prev;
      assign prev = cell_data[k*MOD_BITS-1];
      always_comb begin
        entry_valid[k] = cell_valid[k*MOD_BITS-1];
        entry_data[k]  = prev;
        if (k == 1) begin
          {entry_data[k].mul[1], entry_data[k].mul[0]} =
            lane_setup(MOD_ONE, prev.mul[0].p, prev.sec_a[J]);
          {entry_data[k].mul[3], entry_data[k].mul[2]} =
            lane_setup(MOD_ONE, prev.mul[0].p, prev.sec_b[J]);
        end else if (k == MOD_BITS + 1) begin
          entry_data[k].pub_a = prev.mul[0].p;
          entry_data[k].pub_b = prev.mul[2].p;
          {entry_data[k].mul[1], entry_data[k].mul[0]} =
            lane_setup(MOD_ONE, prev.mul[2].p, prev.sec_a[J]);
          {entry_data[k].mul[3], entry_data[k].mul[2]} =
            lane_setup(MOD_ONE, prev.mul[0].p, prev.sec_b[J]);
        end else begin
          {entry_data[k].mul[1], entry_data[k].mul[0]} =
            lane_setup(prev.mul[0].p, prev.mul[1].p, prev.sec_a[J]);
          {entry_data[k].mul[3], entry_data[k].mul[2]} =
            lane_setup(prev.mul[2].p, prev.mul[3].p, prev.sec_b[J]);
        end
      end
    end

    for (genvar c = 0; c < MOD_BITS; c++) begin : g_cell
      localparam int S = k * MOD_BITS + c;
      cell_ctrl_t ctrl;
      stage_t     din;
      if (c == 0) begin : g_first
        assign ctrl = '{en: en, valid: entry_valid[k]};
        assign din  = entry_data[k];
      end else begin : g_next
        assign ctrl = '{en: en, valid: cell_valid[S-1]};
        assign din  = cell_data[S-1];
      end
      dhkp_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .modulus_i (modulus_q),
        .data_i    (din),
        .valid_o   (cell_valid[S]),
        .data_o    (cell_data[S])
      );
    end
  end

  logic   last_valid;
  stage_t last_data;
  logic   zero_mod;
  assign last_valid = cell_valid[NUM_STAGES-1];
  assign last_data  = cell_data[NUM_STAGES-1];
  assign zero_mod   = modulus_q < MOD_TWO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_valid) begin
      pub_a_q <= zero_mod ? '0 : last_data.pub_a;
      pub_b_q <= zero_mod ? '0 : last_data.pub_b;
      key_a_q <= zero_mod ? '0 : last_data.mul[0].p;
      key_b_q <= zero_mod ? '0 : last_data.mul[2].p;
    end
  end

  assign out_valid_o = out_valid_q;
  assign public_a_o  = pub_a_q;
  assign public_b_o  = pub_b_q;
  assign key_a_o     = key_a_q;
  assign key_b_o     = key_b_q;

`ifndef SYNTH
  a_out_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last_valid))
    else $error("result appeared without a request at the chain end");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a waiting result");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && last_valid) |=> (cell_valid[NUM_STAGES-1] && out_valid_q))
    else $error("request lost at chain end during stall");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for diffie_hellman_key_pair: directed and random requests
// with bursty input, random output stalls and one long output hold-off
// depends on dhkp_pkg and the diffie_hellman_key_pair rtl
module tb;
  import dhkp_pkg::*;

  typedef logic [MOD_BITS-1:0] word_t;

  typedef struct packed {
    word_t public_a;
    word_t public_b;
    word_t key_a;
    word_t key_b;
  } key_set_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i = 1'b0;
  logic  cfg_idx_i = REG_MODULUS;
  word_t cfg_data_i = '0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  word_t secret_a_i = '0;
  word_t secret_b_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  word_t public_a_o, public_b_o, key_a_o, key_b_o;

  diffie_hellman_key_pair dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  word_t    shadow_modulus = RESET_MODULUS;
  word_t    shadow_generator = RESET_GENERATOR;
  key_set_t pending_keys[$];
  int       mismatches = 0;
  int       burst_left = 0;
  int       stall_pct = 0;
  int       hold_cycles = 0;
  bit       hold_request = 1'b0;

  function automatic word_t mod_pow(word_t base, word_t e, word_t m);
    logic [2*MOD_BITS-1:0] acc;
    logic [2*MOD_BITS-1:0] b;
    acc = 1 % m;
    b = base % m;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (e[i]) acc = (acc * b) % m;
      b = (b * b) % m;
    end
    return acc[MOD_BITS-1:0];
  endfunction

  function automatic key_set_t predict_key_set(word_t a, word_t b);
    key_set_t r;
    r = '0;
    if (shadow_modulus >= MOD_TWO) begin
      r.public_a = mod_pow(shadow_generator, a, shadow_modulus);
      r.public_b = mod_pow(shadow_generator, b, shadow_modulus);
      r.key_a = mod_pow(r.public_b, a, shadow_modulus);
      r.key_b = mod_pow(r.public_a, b, shadow_modulus);
    end
    return r;
  endfunction

  // values read here are those from before the edge
  always @(posedge clk_i) begin
    key_set_t want;
    if (rst_ni && cfg_we_i) begin
      if (cfg_idx_i == REG_MODULUS) shadow_modulus <= cfg_data_i;
      else shadow_generator <= cfg_data_i;
    end
    if (rst_ni && in_valid_i && !in_stall_o)
      pending_keys = {pending_keys, predict_key_set(secret_a_i, secret_b_i)};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h %h",
                                       public_a_o, public_b_o, key_a_o, key_b_o);
      end else begin
        want = pending_keys.pop_front();
        if (want.public_a !== public_a_o || want.public_b !== public_b_o ||
            want.key_a !== key_a_o || want.key_b !== key_b_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %h got %h %h %h %h",
                     want.public_a, want.public_b, want.key_a, want.key_b,
                     public_a_o, public_b_o, key_a_o, key_b_o);
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request && hold_cycles == 0) begin
      hold_cycles = 2000;
      hold_request = 1'b0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(word_t a, word_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    secret_a_i <= a;
    secret_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_keys.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, word_t value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    repeat (n) send_request(word_t'($urandom), word_t'($urandom));
  endtask

  task automatic test_reset_config();
    stall_pct = 0;
    send_request(16'd1, 16'd1);
    send_request(16'hffff, 16'hffff);
    send_request(16'd0, 16'h1234);
    send_request(16'haaaa, 16'h5555);
    send_request(16'h5555, 16'd0);
    stall_pct = 30;
    send_request(16'h8000, 16'h0001);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_MODULUS, 16'd0);
    send_request(16'd5, 16'd9);
    send_request(16'd0, 16'd0);
    write_reg(REG_MODULUS, 16'd1);
    send_request(16'd3, 16'hffff);
    write_reg(REG_MODULUS, 16'd2);
    write_reg(REG_GENERATOR, 16'hffff);
    send_request(16'd7, 16'd0);
    write_reg(REG_MODULUS, 16'd3);
    send_request(16'hffff, 16'd2);
    write_reg(REG_MODULUS, 16'hffff);
    write_reg(REG_GENERATOR, 16'd0);
    send_request(16'd0, 16'd4);
    send_request(16'h00ff, 16'hff00);
    write_reg(REG_GENERATOR, 16'hfffe);
    send_request(16'hffff, 16'hfffe);
    write_reg(REG_MODULUS, 16'd65521);
    write_reg(REG_GENERATOR, 16'd17);
    send_request(16'h1357, 16'h2468);
    send_request(16'd1, 16'hffff);
    write_reg(REG_GENERATOR, 16'd65521);
    send_request(16'd4, 16'd6);
    write_reg(REG_MODULUS, 16'd1000);
    write_reg(REG_GENERATOR, 16'd3);
    send_request(16'h0f0f, 16'hf0f0);
  endtask

  task automatic test_random_settings();
    word_t primes[6] = '{16'd65521, 16'd7489, 16'd65519, 16'd251, 16'd3, 16'd40009};
    for (int phase = 0; phase < 6; phase++) begin
      stall_pct = $urandom_range(50);
      if (phase % 2 == 0) write_reg(REG_MODULUS, primes[$urandom_range(5)]);
      else write_reg(REG_MODULUS, word_t'($urandom));
      write_reg(REG_GENERATOR, word_t'($urandom));
      send_random(100);
    end
  endtask

  task automatic test_output_hold();
    write_reg(REG_MODULUS, 16'd65521);
    write_reg(REG_GENERATOR, 16'd7);
    stall_pct = 10;
    hold_request = 1'b1;
    send_random(600);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_register_extremes();
    test_random_settings();
    test_output_hold();
    drain();
    stall_pct = 0;
    repeat (560) @(posedge clk_i);
    if (mismatches == 0 && pending_keys.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
src/dhkp_pkg.sv
src/dhkp_cell.sv
src/diffie_hellman_key_pair.sv
tb/tb.sv
